FILE: rtl/sha256md_pkg.sv
// sha256md_pkg: shared types, constants and round functions for the sha-256 digest block
// used by sha256md_sched, sha256md_round and sha256_message_digest_top; no dependencies
package sha256md_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [2:0] WORD_BYTES = 3'd4;

	// schedule buffer operations
	typedef enum logic [2:0] {
		SCH_HOLD,
		SCH_BYTE,
		SCH_PAD,
		SCH_LEN,
		SCH_SHIFT
	} sch_op_t;

	typedef struct packed {
		sch_op_t     op;
		logic [5:0]  pos;
		logic [7:0]  data;
		logic        expand;
		logic        with_len;
	} sched_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t round_k(input logic [5:0] r);
		case (r)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

FILE: rtl/sha256_message_digest_top.sv
// sha256_message_digest_top: streaming sha-256 digest with byte packing and padding
// depends on sha256md_pkg, sha256md_sched, sha256md_round
// each word: an accept, then one byte packed per cycle (held while a full block compresses), then a close
// a full block adds 64 rounds of the single shared round unit plus the chain add
// the last word adds padding and one block, plus a length step and a second block when one is needed,
// then eight digest words, one per output handshake
// reset clears the chain to the initial hash, the byte count and the fill; no clearing pass
module sha256_message_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_item,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_BYTE,
		S_COMP,
		S_ADD,
		S_PAD,
		S_LEN,
		S_OUT
	} state_t;

	// where to go once a block has been folded into the chain
	typedef enum logic [1:0] {
		RET_BYTE,
		RET_LEN,
		RET_OUT
	} ret_t;

	state_t                   state_q;
	ret_t                     ret_q;
	logic [31:0]              word_q;
	logic [2:0]               cnt_q;
	logic [2:0]               k_q;
	logic                     last_q;
	logic [5:0]               fill_q;
	logic [60:0]              byte_cnt_q;
	logic [5:0]               round_q;
	logic [2:0]               idx_q;
	sha256md_pkg::hash_t      chain_q;
	sha256md_pkg::hash_t      vars;
	sha256md_pkg::word_t      w_round;
	sha256md_pkg::sched_ctl_t sch_ctl;
	sha256md_pkg::round_ctl_t rnd_ctl;
	logic                     byte_go;
	logic [7:0]               cur_byte;

	// a byte of the held word is still to be packed
	assign byte_go = (state_q == S_BYTE) && (k_q != cnt_q);

	always_comb begin
		case (k_q[1:0])
			2'd0:    cur_byte = word_q[31:24];
			2'd1:    cur_byte = word_q[23:16];
			2'd2:    cur_byte = word_q[15:8];
			default: cur_byte = word_q[7:0];
		endcase
	end

	// control to the schedule buffer
	always_comb begin
		sch_ctl.op       = sha256md_pkg::SCH_HOLD;
		sch_ctl.pos      = fill_q;
		sch_ctl.data     = cur_byte;
		sch_ctl.expand   = (round_q[5:4] != 2'b00);
		sch_ctl.with_len = (fill_q < sha256md_pkg::LEN_OFFSET);
		if (byte_go) begin
			sch_ctl.op = sha256md_pkg::SCH_BYTE;
		end else if (state_q == S_PAD) begin
			sch_ctl.op   = sha256md_pkg::SCH_PAD;
			sch_ctl.data = sha256md_pkg::PAD_BYTE;
		end else if (state_q == S_LEN) begin
			sch_ctl.op = sha256md_pkg::SCH_LEN;
		end else if (state_q == S_COMP) begin
			sch_ctl.op = sha256md_pkg::SCH_SHIFT;
		end
	end

	// working variables load from the chain as a block starts
	assign rnd_ctl.load = (byte_go && fill_q == 6'd63) || state_q == S_PAD || state_q == S_LEN;
	assign rnd_ctl.step = (state_q == S_COMP);

	sha256md_sched u_sched (
		.clk     (clk),
		.ctl     (sch_ctl),
		.bit_len ({byte_cnt_q, 3'b000}),
		.w_round (w_round)
	);

	sha256md_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rnd_ctl),
		.chain   (chain_q),
		.k_const (sha256md_pkg::round_k(round_q)),
		.w_round (w_round),
		.vars    (vars)
	);

	// handshake and digest word out of the chain register
	assign msg_stall   = (state_q != S_IDLE);
	assign dig_valid   = (state_q == S_OUT);
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= RET_BYTE;
			word_q     <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			last_q     <= 1'b0;
			fill_q     <= '0;
			byte_cnt_q <= '0;
			round_q    <= '0;
			idx_q      <= '0;
			chain_q    <= sha256md_pkg::INIT_HASH;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						word_q  <= message_word;
						// counts above four take the whole word
						cnt_q   <= (valid_bytes > sha256md_pkg::WORD_BYTES) ?
						           sha256md_pkg::WORD_BYTES : valid_bytes;
						last_q  <= last_item;
						k_q     <= '0;
						state_q <= S_BYTE;
					end
				end
				S_BYTE: begin
					if (k_q != cnt_q) begin
						k_q        <= k_q + 3'd1;
						fill_q     <= fill_q + 6'd1;
						byte_cnt_q <= byte_cnt_q + 61'd1;
						// block full: compress before the next byte
						if (fill_q == 6'd63) begin
							round_q <= '0;
							ret_q   <= RET_BYTE;
							state_q <= S_COMP;
						end
					end else begin
						state_q <= last_q ? S_PAD : S_IDLE;
					end
				end
				S_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63)
						state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= chain_q[i] + vars[i];
					case (ret_q)
						RET_BYTE: state_q <= S_BYTE;
						RET_LEN:  state_q <= S_LEN;
						default: begin
							idx_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_PAD: begin
					// length lands in this block unless too few bytes are left
					round_q <= '0;
					ret_q   <= (fill_q < sha256md_pkg::LEN_OFFSET) ? RET_OUT : RET_LEN;
					state_q <= S_COMP;
				end
				S_LEN: begin
					round_q <= '0;
					ret_q   <= RET_OUT;
					state_q <= S_COMP;
				end
				S_OUT: begin
					if (!dig_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							chain_q    <= sha256md_pkg::INIT_HASH;
							fill_q     <= '0;
							byte_cnt_q <= '0;
							state_q    <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// byte counter never passes the held count
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BYTE |-> k_q <= cnt_q)
		else $error("byte index past valid count");

	// compression ends with the chain add after round 63
	a_comp_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMP && round_q == 6'd63 |=> state_q == S_ADD)
		else $error("compression did not end in chain add");

	// digest output and input acceptance never overlap
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input open during digest output");

	// after the eighth digest word the message state is cleared
	a_msg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && last_word |=> fill_q == 6'd0 && byte_cnt_q == 61'd0)
		else $error("message state not cleared after digest");

endmodule

FILE: rtl/sha256md_sched.sv
// sha256md_sched: 16-word block buffer, byte packing, padding and rolling schedule
// depends on sha256md_pkg
module sha256md_sched (
	input  logic                     clk,
	input  sha256md_pkg::sched_ctl_t ctl,
	input  logic [63:0]              bit_len,
	output sha256md_pkg::word_t      w_round
);

	sha256md_pkg::word_t win_q [16];
	sha256md_pkg::word_t w_new;
	logic [3:0]  wi;
	logic [1:0]  lane;
	logic [31:0] lane_mask;
	logic [31:0] keep_mask;
	logic [31:0] pad_word;
	logic [31:0] byte_word;

	assign wi   = ctl.pos[5:2];
	assign lane = ctl.pos[1:0];
	assign lane_mask = 32'hff000000 >> {lane, 3'b000};
	assign keep_mask = ~(32'hffffffff >> {lane, 3'b000});
	assign pad_word  = {ctl.data, 24'h000000} >> {lane, 3'b000};
	assign byte_word = {ctl.data, 24'h000000} >> {lane, 3'b000};

	// expanded word for rounds 16 to 63, plain buffer word before that
	assign w_new = win_q[0] + sha256md_pkg::small_sigma0(win_q[1]) + win_q[9]
	             + sha256md_pkg::small_sigma1(win_q[14]);
	assign w_round = ctl.expand ? w_new : win_q[0];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 16; j++) begin
			case (ctl.op)
				sha256md_pkg::SCH_BYTE: begin
					if (wi == 4'(j))
						win_q[j] <= (win_q[j] & ~lane_mask) | byte_word;
				end
				sha256md_pkg::SCH_PAD: begin
					if (ctl.with_len && j == 14)
						win_q[j] <= bit_len[63:32];
					else if (ctl.with_len && j == 15)
						win_q[j] <= bit_len[31:0];
					else if (wi == 4'(j))
						win_q[j] <= (win_q[j] & keep_mask) | pad_word;
					else if (4'(j) > wi)
						win_q[j] <= '0;
				end
				sha256md_pkg::SCH_LEN: begin
					if (j == 14)
						win_q[j] <= bit_len[63:32];
					else if (j == 15)
						win_q[j] <= bit_len[31:0];
					else
						win_q[j] <= '0;
				end
				sha256md_pkg::SCH_SHIFT: begin
					if (j == 15)
						win_q[j] <= w_round;
					else
						win_q[j] <= win_q[(j + 1) % 16];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/sha256md_round.sv
// sha256md_round: working variables a..h and the shared compression round
// depends on sha256md_pkg
module sha256md_round (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha256md_pkg::round_ctl_t ctl,
	input  sha256md_pkg::hash_t      chain,
	input  sha256md_pkg::word_t      k_const,
	input  sha256md_pkg::word_t      w_round,
	output sha256md_pkg::hash_t      vars
);

	sha256md_pkg::hash_t v_q;
	sha256md_pkg::word_t t1;
	sha256md_pkg::word_t t2;
	sha256md_pkg::word_t ch;
	sha256md_pkg::word_t maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sha256md_pkg::big_sigma1(v_q[4]) + ch + k_const + w_round;
	assign t2  = sha256md_pkg::big_sigma0(v_q[0]) + maj;
	assign vars = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctl.load) begin
			v_q <= chain;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
